@@ design/imhka_pkg.sv @@
package imhka_pkg;

  // Heap geometry
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned HADDR_W  = $clog2(CAPACITY);
  localparam int unsigned SLOT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W  = SLOT_W + 1;
  localparam int unsigned TOTAL_W  = 11;
  localparam int unsigned STATUS_W = 2;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ADJUST = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic [ID_W-1:0]         item_id;
    logic signed [KEY_W-1:0] new_key;
    logic signed [KEY_W-1:0] delta;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    logic [ID_W-1:0]         min_id;
    logic                    min_valid;
    logic [TOTAL_W-1:0]      entry_total;
    logic [STATUS_W-1:0]     status;
  } rsp_t;

  // One heap slot
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
  } entry_t;

  // One slot map entry; present doubles as the id-present flag
  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } smap_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_e;

endpackage

@@ design/indexed_min_heap_key_adjust.sv @@
// Flow: a request is taken in S_IDLE and its id is looked up in the slot map in S_LOOKUP, where a
// rejected request (duplicate, full, unknown id) is flagged. An insert walks up from the new last
// slot through S_UP_RD and S_UP_CMP; an adjust first reads the stored key in S_FETCH and then walks
// up, or down through S_DN_RD and S_DN_CMP. One request is handled at a time, and the heap memory
// read at each level sets the pace.
// Reset: asynchronous; afterwards busy stays high while the slot map is swept clear, one entry
// per cycle. Each result is strobed for one cycle; the receiver cannot stall.
module indexed_min_heap_key_adjust
  import imhka_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  // Memories: heap slots (address = slot - 1) and per-id slot map
  entry_t heap_mem [CAPACITY];
  smap_t  smap_mem [1 << ID_W];

  logic [HADDR_W-1:0] heap_raddr_a, heap_raddr_b, heap_waddr;
  logic               heap_we;
  entry_t             heap_wdata, heap_rd_a_q, heap_rd_b_q;
  logic [ID_W-1:0]    smap_raddr, smap_waddr;
  logic               smap_we;
  smap_t              smap_wdata, smap_rd_q;

  // Control and datapath registers
  state_e                  state_q, state_d;
  logic [SLOT_W-1:0]       cnt_q, cnt_d;
  logic [ID_W-1:0]         clr_q, clr_d;
  logic                    done_q, done_d;
  req_t                    req_q, req_d;
  logic [SLOT_W-1:0]       s_q, s_d;
  logic signed [KEY_W-1:0] mk_q, mk_d;
  logic [ID_W-1:0]         mid_q, mid_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  entry_t                  top_q;

  // Derived slot arithmetic
  logic [SLOT_W-1:0]  parent;
  logic [CHILD_W-1:0] child_l, child_r, cnt_ext;
  logic [HADDR_W-1:0] s_addr;
  logic               use_right, place;
  entry_t             pick;
  logic [SLOT_W-1:0]  pick_slot;

  assign parent    = s_q >> 1;
  assign child_l   = {s_q, 1'b0};
  assign child_r   = child_l + CHILD_W'(1);
  assign cnt_ext   = {1'b0, cnt_q};
  assign s_addr    = HADDR_W'(s_q - SLOT_W'(1));
  assign use_right = (child_r <= cnt_ext) && (heap_rd_b_q.key < heap_rd_a_q.key);
  assign pick      = use_right ? heap_rd_b_q : heap_rd_a_q;
  assign pick_slot = use_right ? SLOT_W'(child_r) : SLOT_W'(child_l);

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    heap_rd_a_q <= heap_mem[heap_raddr_a];
    heap_rd_b_q <= heap_mem[heap_raddr_b];
  end

  // Slot map memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (smap_we) begin
      smap_mem[smap_waddr] <= smap_wdata;
    end
    smap_rd_q <= smap_mem[smap_raddr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (req_q.opcode == OP_INSERT) begin
          if (!smap_rd_q.present && (cnt_q < SLOT_W'(CAPACITY))) state_d = S_UP_RD;
          else state_d = S_IDLE;
        end else begin
          if (smap_rd_q.present) state_d = S_FETCH;
          else state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        if (!req_q.delta[KEY_W-1] && (req_q.delta != '0)) state_d = S_UP_RD;
        else state_d = S_DN_RD;
      end
      S_UP_RD: begin
        if (s_q == SLOT_W'(1)) state_d = S_IDLE;
        else state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (mk_q < heap_rd_a_q.key) state_d = S_UP_RD;
        else state_d = S_IDLE;
      end
      S_DN_RD: begin
        if (child_l > cnt_ext) state_d = S_IDLE;
        else state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (pick.key < mk_q) state_d = S_DN_RD;
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory controls and datapath updates
  always_comb begin
    heap_raddr_a = s_addr;
    heap_raddr_b = s_addr;
    heap_we      = 1'b0;
    heap_waddr   = s_addr;
    heap_wdata   = '{key: mk_q, id: mid_q};
    smap_raddr   = req_i.item_id;
    smap_we      = 1'b0;
    smap_waddr   = mid_q;
    smap_wdata   = '{present: 1'b1, slot: s_q};
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    done_d       = 1'b0;
    req_d        = req_q;
    s_d          = s_q;
    mk_d         = mk_q;
    mid_d        = mid_q;
    status_d     = status_q;
    place        = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // sweep the slot map clear
        smap_we    = 1'b1;
        smap_waddr = clr_q;
        smap_wdata = '0;
        clr_d      = clr_q + ID_W'(1);
      end
      S_IDLE: begin
        // take a request and look up its id
        if (start) req_d = req_i;
      end
      S_LOOKUP: begin
        mid_d = req_q.item_id;
        if (req_q.opcode == OP_INSERT) begin
          if (smap_rd_q.present) begin
            status_d = STATUS_DUP;
            done_d   = 1'b1;
          end else if (cnt_q >= SLOT_W'(CAPACITY)) begin
            status_d = STATUS_FULL;
            done_d   = 1'b1;
          end else begin
            cnt_d    = cnt_q + SLOT_W'(1);
            s_d      = cnt_q + SLOT_W'(1);
            mk_d     = req_q.new_key;
            status_d = STATUS_OK;
          end
        end else begin
          if (!smap_rd_q.present) begin
            status_d = STATUS_UNKNOWN;
            done_d   = 1'b1;
          end else begin
            s_d          = smap_rd_q.slot;
            heap_raddr_a = HADDR_W'(smap_rd_q.slot - SLOT_W'(1));
            status_d     = STATUS_OK;
          end
        end
      end
      S_FETCH: begin
        // apply the delta to the stored key
        mk_d = heap_rd_a_q.key - req_q.delta;
      end
      S_UP_RD: begin
        if (s_q == SLOT_W'(1)) place = 1'b1;
        else heap_raddr_a = HADDR_W'(parent - SLOT_W'(1));
      end
      S_UP_CMP: begin
        // move the parent down into the hole, or stop
        if (mk_q < heap_rd_a_q.key) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rd_a_q;
          smap_we    = 1'b1;
          smap_waddr = heap_rd_a_q.id;
          s_d        = parent;
        end else begin
          place = 1'b1;
        end
      end
      S_DN_RD: begin
        if (child_l > cnt_ext) begin
          place = 1'b1;
        end else begin
          heap_raddr_a = HADDR_W'(child_l - CHILD_W'(1));
          heap_raddr_b = HADDR_W'(child_l);
        end
      end
      S_DN_CMP: begin
        // move the smaller child up into the hole, or stop
        if (pick.key < mk_q) begin
          heap_we    = 1'b1;
          heap_wdata = pick;
          smap_we    = 1'b1;
          smap_waddr = pick.id;
          s_d        = pick_slot;
        end else begin
          place = 1'b1;
        end
      end
      default: ;
    endcase
    // drop the moving entry into its final slot and report
    if (place) begin
      heap_we = 1'b1;
      smap_we = 1'b1;
      done_d  = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    s_q      <= s_d;
    mk_q     <= mk_d;
    mid_q    <= mid_d;
    status_q <= status_d;
  end

  // Shadow copy of slot 1
  always_ff @(posedge clk_i) begin
    if (heap_we && (heap_waddr == '0)) begin
      top_q <= heap_wdata;
    end
  end

  // Result
  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = done_q;
  always_comb begin
    rsp_o.min_valid   = (cnt_q != '0);
    rsp_o.min_key     = rsp_o.min_valid ? top_q.key : '0;
    rsp_o.min_id      = rsp_o.min_valid ? top_q.id : '0;
    rsp_o.entry_total = TOTAL_W'(cnt_q);
    rsp_o.status      = status_q;
  end

endmodule

@@ dv/tb_indexed_min_heap_key_adjust.sv @@
`timescale 1ns / 1ps

module tb_indexed_min_heap_key_adjust;
  import imhka_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned FILL_ITEMS  = 60;
  localparam int unsigned DEEP_ITEMS  = 40;
  localparam int unsigned ID_SPACE    = 1 << ID_W;

  // Shadow of the indexed heap: predicts the minimum report of every request
  class heap_shadow;
    logic signed [KEY_W-1:0] keys [1:CAPACITY];
    logic [ID_W-1:0]         ids  [1:CAPACITY];
    int unsigned             slot_of [ID_SPACE];
    bit                      present [ID_SPACE];
    int unsigned             count;
    rsp_t                    pending_min_reports[$];
    int unsigned             errors, checked, peak;
    int unsigned             n_insert, n_adjust, n_dup, n_unknown, n_full;

    function automatic bit bool_lt(input logic signed [KEY_W-1:0] a,
                                   input logic signed [KEY_W-1:0] b);
      return a < b;
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
      logic signed [KEY_W-1:0] k;
      logic [ID_W-1:0]         d;
      k = keys[a];
      d = ids[a];
      keys[a] = keys[b];
      ids[a] = ids[b];
      keys[b] = k;
      ids[b] = d;
      slot_of[ids[a]] = a;
      slot_of[ids[b]] = b;
    endfunction

    function automatic void raise(input int unsigned s);
      while (s > 1 && s <= CAPACITY && bool_lt(keys[s], keys[s / 2])) begin
        swap_slots(s, s / 2);
        s = s / 2;
      end
    endfunction

    function automatic void lower(input int unsigned s);
      int unsigned c;
      while (s >= 1 && 2 * s <= count) begin
        c = 2 * s;
        if (c + 1 <= count && bool_lt(keys[c + 1], keys[c])) c++;
        if (!bool_lt(keys[c], keys[s])) break;
        swap_slots(s, c);
        s = c;
      end
    endfunction

    // Apply an accepted request and queue the report it must produce
    function automatic void note_request(input req_t r);
      rsp_t        exp;
      int unsigned s;
      exp = '0;
      exp.status = STATUS_OK;
      if (r.opcode == OP_INSERT) begin
        if (present[r.item_id]) begin
          exp.status = STATUS_DUP;
          n_dup++;
        end else if (count >= CAPACITY) begin
          exp.status = STATUS_FULL;
          n_full++;
        end else begin
          count++;
          keys[count] = r.new_key;
          ids[count] = r.item_id;
          slot_of[r.item_id] = count;
          present[r.item_id] = 1'b1;
          raise(count);
          n_insert++;
        end
      end else begin
        if (!present[r.item_id]) begin
          exp.status = STATUS_UNKNOWN;
          n_unknown++;
        end else begin
          s = slot_of[r.item_id];
          keys[s] = keys[s] - r.delta;
          // a positive delta lowers the key; zero and negative walk down
          if (!r.delta[KEY_W-1] && r.delta != 0) raise(s);
          else lower(s);
          n_adjust++;
        end
      end
      if (count > peak) peak = count;
      if (count > 0) begin
        exp.min_key = keys[1];
        exp.min_id = ids[1];
        exp.min_valid = 1'b1;
      end
      exp.entry_total = count[TOTAL_W-1:0];
      pending_min_reports = {pending_min_reports, exp};
    endfunction

    // Compare one strobed report with the oldest prediction
    function automatic void check_report(input rsp_t got);
      rsp_t exp;
      if (pending_min_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: key=%0d id=%0d valid=%0b total=%0d status=%0d",
                 $time, got.min_key, got.min_id, got.min_valid, got.entry_total, got.status);
        return;
      end
      exp = pending_min_reports.pop_front();
      checked++;
      if (got.min_key !== exp.min_key || got.min_id !== exp.min_id ||
          got.min_valid !== exp.min_valid || got.entry_total !== exp.entry_total ||
          got.status !== exp.status) begin
        errors++;
        $display("%0t: mismatch, expected key=%0d id=%0d valid=%0b total=%0d status=%0d",
                 $time, exp.min_key, exp.min_id, exp.min_valid, exp.entry_total, exp.status);
        $display("%0t:           actual   key=%0d id=%0d valid=%0b total=%0d status=%0d",
                 $time, got.min_key, got.min_id, got.min_valid, got.entry_total, got.status);
      end
    endfunction

    function automatic int unsigned pending();
      return pending_min_reports.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  heap_shadow  heap;
  int unsigned cycle_count;
  int unsigned items_sent;
  req_t        directed_q[$];

  indexed_min_heap_key_adjust u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1) heap.check_report(rsp_o);
  end

  function automatic req_t make_req(input logic op, input int unsigned id,
                                    input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] dl);
    req_t r;
    r.opcode = op;
    r.item_id = id[ID_W-1:0];
    r.new_key = key;
    r.delta = dl;
    return r;
  endfunction

  // Append one request to the directed list
  function automatic void add_directed(input req_t r);
    directed_q = {directed_q, r};
  endfunction

  function automatic int unsigned pick_id(input bit want_present);
    int unsigned id;
    do id = $urandom_range(ID_SPACE - 1); while (heap.present[id] != want_present);
    return id;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return 32'h7FFF_FFFF;
    if (roll < 6) return 32'h8000_0000;
    if (roll < 9) return '0;
    if (roll < 40) return $urandom_range(64) - 32;
    return $urandom;
  endfunction

  function automatic logic [KEY_W-1:0] rand_delta();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 14) return 32'h7FFF_FFFF;
    if (roll < 18) return 32'h8000_0000;
    if (roll < 22) return 32'hFFFF_FFFF;
    if (roll < 60) return $urandom_range(2000) - 1000;
    return $urandom;
  endfunction

  // Mostly well-formed traffic; some duplicate inserts and unknown-id adjusts
  function automatic req_t random_request();
    int unsigned roll;
    roll = $urandom_range(99);
    if (heap.count == 0) roll = (roll < 90) ? 0 : 95;
    if (heap.count >= ID_SPACE && (roll < 45 || roll >= 93)) roll = 88;
    if (roll < 45) return make_req(OP_INSERT, pick_id(1'b0), rand_key(), $urandom);
    if (roll < 85) return make_req(OP_ADJUST, pick_id(1'b1), $urandom, rand_delta());
    if (roll < 93) return make_req(OP_INSERT, pick_id(1'b1), rand_key(), $urandom);
    return make_req(OP_ADJUST, pick_id(1'b0), $urandom, rand_delta());
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    heap.note_request(r);
    items_sent++;
  endtask

  // Drop start for a random number of cycles
  task automatic hold_off(input int unsigned pct);
    int unsigned gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending until every predicted report has arrived
  task automatic drain_reports();
    start <= 1'b0;
    do @(posedge clk_i); while (heap.pending() != 0);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned pct);
    repeat (n) begin
      send_request(random_request());
      if ($urandom_range(99) < 2) drain_reports();
      else hold_off(pct);
    end
  endtask

  initial begin
    heap = new;
    cycle_count = 0;
    items_sent = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty heap, extremes, duplicates, unknown ids, wraps, ties
    add_directed(make_req(OP_ADJUST, 0, 0, 5));
    add_directed(make_req(OP_INSERT, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    add_directed(make_req(OP_INSERT, 1023, 32'h8000_0000, 32'h7FFF_FFFF));
    add_directed(make_req(OP_INSERT, 512, 0, 32'hFFFF_FFFF));
    add_directed(make_req(OP_INSERT, 1023, 7, 0));
    add_directed(make_req(OP_ADJUST, 5, 32'hFFFF_FFFF, 1));
    add_directed(make_req(OP_ADJUST, 0, 0, 0));
    add_directed(make_req(OP_ADJUST, 0, 0, 32'hFFFF_FFFF));
    add_directed(make_req(OP_ADJUST, 1023, 0, 1));
    add_directed(make_req(OP_ADJUST, 512, 0, 32'h7FFF_FFFF));
    add_directed(make_req(OP_ADJUST, 512, 0, 32'h8000_0000));
    add_directed(make_req(OP_INSERT, 'h155, 32'h5555_5555, 32'hAAAA_AAAA));
    add_directed(make_req(OP_INSERT, 'h2AA, 32'hAAAA_AAAA, 32'h5555_5555));
    add_directed(make_req(OP_INSERT, 3, 100, 0));
    add_directed(make_req(OP_INSERT, 4, 100, 0));
    add_directed(make_req(OP_INSERT, 6, 100, 0));
    add_directed(make_req(OP_ADJUST, 4, 0, 32'h7FFF_FFFF));
    add_directed(make_req(OP_ADJUST, 4, 0, 32'h8000_0000));
    add_directed(make_req(OP_ADJUST, 3, 0, -50));
    add_directed(make_req(OP_ADJUST, 'h2AA, 0, 32'hAAAA_AAAA));
    add_directed(make_req(OP_INSERT, 3, 0, 0));
    foreach (directed_q[i]) begin
      send_request(directed_q[i]);
      hold_off(28);
    end
    drain_reports();

    // Random phases: busy sender, sparse sender, back-to-back
    run_random(PHASE_ITEMS, 28);
    drain_reports();
    run_random(PHASE_ITEMS, 74);
    run_random(PHASE_ITEMS, 0);
    drain_reports();

    // Grow the heap with a burst of inserts, then work it at that depth
    repeat (FILL_ITEMS) begin
      if (heap.count < CAPACITY && heap.count < ID_SPACE) begin
        send_request(make_req(OP_INSERT, pick_id(1'b0), rand_key(), $urandom));
      end
      hold_off(10);
    end
    run_random(DEEP_ITEMS, 28);

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d inserts, %0d adjusts, %0d duplicates, %0d unknown ids,",
             items_sent, heap.n_insert, heap.n_adjust, heap.n_dup, heap.n_unknown);
    $display("%0d full rejects; heap peaked at %0d entries; %0d reports checked, %0d errors",
             heap.n_full, heap.peak, heap.checked, heap.errors);
    if (heap.errors == 0 && heap.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
